[rtl/recovery_watchdog_backoff_core_assert.svh]
// assertion macros of the watchdog core
`ifndef RECOVERY_WATCHDOG_BACKOFF_CORE_ASSERT_SVH
`define RECOVERY_WATCHDOG_BACKOFF_CORE_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define RWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define RWB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rwb_pkg.sv]
// types and constants of the recovery watchdog
`timescale 1ns / 1ps

package rwb_pkg;

  localparam int unsigned MAX_SHIFT = 3;
  // width of the shifted idle wait
  localparam int unsigned WAIT_W    = 32 + MAX_SHIFT;
  localparam int unsigned SHIFT_W   = $clog2(MAX_SHIFT + 2);

  localparam logic [31:0] RESTART_DELAY_RST = 32'd60000;
  localparam logic [31:0] IDLE_DELAY_RST    = 32'd90000;

  localparam logic CFG_RESTART_DELAY = 1'b0;
  localparam logic CFG_IDLE_DELAY    = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_REMOUNT = 2'd2
  } action_e;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        fault_latch;
    logic        ctrl_rdy;
    logic        session_live;
    logic [31:0] mount_gen;
    logic [31:0] dispatch_cnt;
  } obs_t;

  typedef struct packed {
    logic [31:0] restart_delay_ms;
    logic [31:0] idle_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic fault_armed;
    logic restart_sent;
    logic remount_sent;
  } status_t;

endpackage

[rtl/recovery_watchdog_backoff_core.sv]
// path: an accepted transaction is held in the input register, its action in the output register
// throughput: one observation per cycle; the input register advances whenever the output
// register is empty or being taken, the decision logic reads the state registers directly
// reset: all watchdog state clears, the delay registers return to 60000 and 90000 ms
// no clearing pass is needed, transactions are taken right after reset
`timescale 1ns / 1ps

module recovery_watchdog_backoff_core import rwb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] now_ms_i,
  input  logic        fault_latch_i,
  input  logic        ctrl_rdy_i,
  input  logic        session_live_i,
  input  logic [31:0] mount_gen_i,
  input  logic [31:0] dispatch_cnt_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

`include "recovery_watchdog_backoff_core_assert.svh"

  logic    s1_valid_q;
  obs_t    s1_obs_q;
  cfg_t    cfg_q;
  logic    advance;
  logic    in_accept;
  logic    step;
  action_e step_action;
  status_t status;
  action_e action_q;

  assign advance    = !out_valid_o || !out_stall_i;
  assign step       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.restart_delay_ms <= RESTART_DELAY_RST;
      cfg_q.idle_delay_ms    <= IDLE_DELAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RESTART_DELAY: cfg_q.restart_delay_ms <= cfg_data_i;
        CFG_IDLE_DELAY:    cfg_q.idle_delay_ms    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_obs_q.now_ms       <= now_ms_i;
      s1_obs_q.fault_latch  <= fault_latch_i;
      s1_obs_q.ctrl_rdy     <= ctrl_rdy_i;
      s1_obs_q.session_live <= session_live_i;
      s1_obs_q.mount_gen    <= mount_gen_i;
      s1_obs_q.dispatch_cnt <= dispatch_cnt_i;
    end
  end

  rwb_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .obs_i    (s1_obs_q),
    .cfg_i    (cfg_q),
    .action_o (step_action),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      action_q <= step_action;
    end
  end

  assign action_o = action_q;

  `RWB_ASSERT(a_stall_only_full, !in_stall_o || s1_valid_q, "stall while input register empty")
  `RWB_ASSERT_NEXT(a_step_fills_out, step, out_valid_o, "processed transaction lost")
  `RWB_ASSERT_NEXT(a_restart_once, step && (step_action == ACT_RESTART),
                   status.restart_sent && status.fault_armed, "restart not latched")
  `RWB_ASSERT_NEXT(a_remount_once, step && (step_action == ACT_REMOUNT),
                   status.remount_sent && !status.fault_armed, "remount not latched")

endmodule

[rtl/rwb_engine.sv]
// watchdog state and the per-observation decision logic
`timescale 1ns / 1ps

module rwb_engine import rwb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  obs_t    obs_i,
  input  cfg_t    cfg_i,
  output action_e action_o,
  output status_t status_o
);

  logic        fault_armed_q, fault_armed_d;
  logic [31:0] fatal_start_q, fatal_start_d;
  logic        restart_sent_q, restart_sent_d;
  logic        idle_tracking_q, idle_tracking_d;
  logic        remount_sent_q, remount_sent_d;
  logic [31:0] idle_start_q, idle_start_d;
  logic [31:0] tracked_gen_q, tracked_gen_d;
  logic [31:0] last_disp_q, last_disp_d;
  logic [7:0]  streak_q, streak_d;

  logic [31:0]        fatal_start_eff;
  logic [31:0]        fatal_elapsed;
  logic [31:0]        idle_elapsed;
  logic [SHIFT_W-1:0] shift;
  logic [WAIT_W-1:0]  idle_wait;
  logic               idle_block;
  logic               idle_restart;

  always_comb begin
    fatal_start_eff = fault_armed_q ? fatal_start_q : obs_i.now_ms;
    fatal_elapsed   = obs_i.now_ms - fatal_start_eff;
    idle_elapsed    = obs_i.now_ms - idle_start_q;
    shift           = (streak_q > 8'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : streak_q[SHIFT_W-1:0];
    idle_wait       = WAIT_W'(cfg_i.idle_delay_ms) << shift;
    idle_block      = !obs_i.ctrl_rdy || obs_i.session_live ||
                      (obs_i.mount_gen == 32'd0) || (cfg_i.idle_delay_ms == 32'd0);
    idle_restart    = !idle_tracking_q || (tracked_gen_q != obs_i.mount_gen) ||
                      (last_disp_q != obs_i.dispatch_cnt);
  end

  always_comb begin
    fault_armed_d   = fault_armed_q;
    fatal_start_d   = fatal_start_q;
    restart_sent_d  = restart_sent_q;
    idle_tracking_d = idle_tracking_q;
    remount_sent_d  = remount_sent_q;
    idle_start_d    = idle_start_q;
    tracked_gen_d   = tracked_gen_q;
    last_disp_d     = last_disp_q;
    streak_d        = streak_q;
    action_o        = ACT_NONE;
    if (!obs_i.fault_latch) begin
      fault_armed_d  = 1'b0;
      fatal_start_d  = 32'd0;
      restart_sent_d = 1'b0;
      if (idle_block) begin
        idle_tracking_d = 1'b0;
        remount_sent_d  = 1'b0;
        tracked_gen_d   = obs_i.mount_gen;
        last_disp_d     = obs_i.dispatch_cnt;
      end else if (idle_restart) begin
        // new dispatch activity clears the backoff
        if (last_disp_q != obs_i.dispatch_cnt) begin
          streak_d = 8'd0;
        end
        idle_tracking_d = 1'b1;
        remount_sent_d  = 1'b0;
        idle_start_d    = obs_i.now_ms;
        tracked_gen_d   = obs_i.mount_gen;
        last_disp_d     = obs_i.dispatch_cnt;
      end else if (obs_i.now_ms < idle_start_q) begin
        idle_start_d = obs_i.now_ms;
      end else if (!remount_sent_q && (WAIT_W'(idle_elapsed) >= idle_wait)) begin
        remount_sent_d = 1'b1;
        if (streak_q != 8'hff) begin
          streak_d = streak_q + 8'd1;
        end
        action_o = ACT_REMOUNT;
      end
    end else if (fault_armed_q && (obs_i.now_ms < fatal_start_q)) begin
      // clock went backwards, re-arm the restart timer
      fatal_start_d = obs_i.now_ms;
    end else begin
      fault_armed_d = 1'b1;
      fatal_start_d = fatal_start_eff;
      if (!restart_sent_q && (fatal_elapsed >= cfg_i.restart_delay_ms)) begin
        restart_sent_d = 1'b1;
        action_o       = ACT_RESTART;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_armed_q   <= 1'b0;
      fatal_start_q   <= 32'd0;
      restart_sent_q  <= 1'b0;
      idle_tracking_q <= 1'b0;
      remount_sent_q  <= 1'b0;
      idle_start_q    <= 32'd0;
      tracked_gen_q   <= 32'd0;
      last_disp_q     <= 32'd0;
      streak_q        <= 8'd0;
    end else if (step_i) begin
      fault_armed_q   <= fault_armed_d;
      fatal_start_q   <= fatal_start_d;
      restart_sent_q  <= restart_sent_d;
      idle_tracking_q <= idle_tracking_d;
      remount_sent_q  <= remount_sent_d;
      idle_start_q    <= idle_start_d;
      tracked_gen_q   <= tracked_gen_d;
      last_disp_q     <= last_disp_d;
      streak_q        <= streak_d;
    end
  end

  assign status_o.fault_armed  = fault_armed_q;
  assign status_o.restart_sent = restart_sent_q;
  assign status_o.remount_sent = remount_sent_q;

endmodule

[tb/sv/tb_recovery_watchdog_backoff_core.sv]
// testbench of the recovery watchdog: directed table, random phases, backoff cap
`timescale 1ns / 1ps

module tb_recovery_watchdog_backoff_core;
  import rwb_pkg::*;

  typedef struct packed {
    bit          is_cfg;
    logic        reg_idx;
    logic [31:0] reg_val;
    obs_t        o;
    bit          typed;
    action_e     act;
  } row_t;

  typedef struct packed {
    logic [31:0] rdelay;
    logic [31:0] idelay;
    int unsigned step;
    bit          gaps;
    int unsigned n;
  } phase_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] now_ms_i = '0;
  logic        fault_latch_i = 1'b0;
  logic        ctrl_rdy_i = 1'b0;
  logic        session_live_i = 1'b0;
  logic [31:0] mount_gen_i = '0;
  logic [31:0] dispatch_cnt_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  action_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  recovery_watchdog_backoff_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .now_ms_i       (now_ms_i),
    .fault_latch_i  (fault_latch_i),
    .ctrl_rdy_i     (ctrl_rdy_i),
    .session_live_i (session_live_i),
    .mount_gen_i    (mount_gen_i),
    .dispatch_cnt_i (dispatch_cnt_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // watchdog state as the predictor sees it
  logic [31:0] restart_delay, idle_delay;
  logic        fatal_on, restart_done, idle_on, remount_done;
  logic [31:0] fatal_t0, idle_t0, gen_seen, disp_seen;
  logic [7:0]  streak, streak_peak;

  action_e     pending_actions[$];
  row_t        dir_rows[$];
  bit          idle_en = 1'b1;
  int          fail_cnt = 0;
  int          n_obs = 0, n_restart = 0, n_remount = 0, n_cfg = 0;

  // random walk of the observed system
  logic [31:0] walk_now = '0, walk_gen = 32'd1, walk_disp = '0;
  int unsigned fatal_left = 0;

  phase_t plan[7] = '{
    '{32'd5,          32'd3,          4,     1'b1, 100},
    '{32'd0,          32'd1,          2,     1'b0, 80},
    '{32'd30,         32'd12,         10,    1'b1, 100},
    '{32'd60000,      32'd90000,      30000, 1'b1, 80},
    '{32'hFFFF_FFFF,  32'd0,          8,     1'b1, 60},
    '{32'd2,          32'hFFFF_FFFF,  8,     1'b1, 60},
    '{32'd7,          32'd2,          3,     1'b1, 100}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic void clear_watchdog();
    restart_delay = RESTART_DELAY_RST;
    idle_delay    = IDLE_DELAY_RST;
    fatal_on      = 1'b0;
    restart_done  = 1'b0;
    idle_on       = 1'b0;
    remount_done  = 1'b0;
    fatal_t0      = '0;
    idle_t0       = '0;
    gen_seen      = '0;
    disp_seen     = '0;
    streak        = '0;
    streak_peak   = '0;
  endfunction

  function automatic action_e predict_action(obs_t o);
    action_e     act;
    logic [31:0] elapsed;
    logic [47:0] wait_ms;
    int unsigned shift;
    act = ACT_NONE;
    if (!o.fault_latch) begin
      fatal_t0     = '0;
      fatal_on     = 1'b0;
      restart_done = 1'b0;
      if (!o.ctrl_rdy || o.session_live || o.mount_gen == '0 ||
          idle_delay == '0) begin
        idle_on      = 1'b0;
        remount_done = 1'b0;
        gen_seen     = o.mount_gen;
        disp_seen    = o.dispatch_cnt;
      end else if (!idle_on || gen_seen != o.mount_gen ||
                   disp_seen != o.dispatch_cnt) begin
        // a new dispatch clears the backoff, a new generation only restarts the window
        if (disp_seen != o.dispatch_cnt) streak = '0;
        idle_on      = 1'b1;
        remount_done = 1'b0;
        idle_t0      = o.now_ms;
        gen_seen     = o.mount_gen;
        disp_seen    = o.dispatch_cnt;
      end else if (o.now_ms < idle_t0) begin
        idle_t0 = o.now_ms;
      end else begin
        shift   = (streak > MAX_SHIFT) ? MAX_SHIFT : streak;
        wait_ms = {16'b0, idle_delay} << shift;
        elapsed = o.now_ms - idle_t0;
        if (!remount_done && {16'b0, elapsed} >= wait_ms) begin
          remount_done = 1'b1;
          if (streak != 8'd255) streak = streak + 8'd1;
          act = ACT_REMOUNT;
        end
      end
    end else begin
      // idle tracking is left as it is while the latch is set
      if (!fatal_on) begin
        fatal_on = 1'b1;
        fatal_t0 = o.now_ms;
        elapsed  = '0;
      end else if (o.now_ms < fatal_t0) begin
        fatal_t0 = o.now_ms;
        return ACT_NONE;
      end
      elapsed = o.now_ms - fatal_t0;
      if (!restart_done && elapsed >= restart_delay) begin
        restart_done = 1'b1;
        act = ACT_RESTART;
      end
    end
    if (streak > streak_peak) streak_peak = streak;
    return act;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic obs_t rand_obs(int unsigned step_max);
    obs_t        o;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) walk_now = walk_now + $urandom_range(0, step_max);
    else if (r < 88) walk_now = walk_now - $urandom_range(1, step_max);
    else if (r < 95) walk_now = walk_now + $urandom_range(step_max, 4 * step_max);
    else walk_now = $urandom;
    if (fatal_left > 0) begin
      o.fault_latch = 1'b1;
      fatal_left--;
    end else if ($urandom_range(0, 99) < 8) begin
      o.fault_latch = 1'b1;
      fatal_left = $urandom_range(1, 25);
    end else begin
      o.fault_latch = 1'b0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) walk_gen = $urandom;
    if (walk_gen == '0) walk_gen = 32'd1;
    o.mount_gen = (r >= 4 && r < 6) ? 32'd0 : walk_gen;
    r = $urandom_range(0, 99);
    if (r < 5) walk_disp = walk_disp + 32'd1;
    else if (r < 7) walk_disp = $urandom;
    o.now_ms       = walk_now;
    o.ctrl_rdy     = $urandom_range(0, 99) < 90;
    o.session_live = $urandom_range(0, 99) < 8;
    o.dispatch_cnt = walk_disp;
    return o;
  endfunction

  function automatic row_t obs_row(logic [31:0] now, int f, int r, int c,
                                   logic [31:0] g, logic [31:0] d,
                                   int typed = 0, action_e act = ACT_NONE);
    row_t row;
    row = '0;
    row.o.now_ms       = now;
    row.o.fault_latch  = f[0];
    row.o.ctrl_rdy     = r[0];
    row.o.session_live = c[0];
    row.o.mount_gen    = g;
    row.o.dispatch_cnt = d;
    row.typed = typed[0];
    row.act   = act;
    return row;
  endfunction

  function automatic row_t cfg_row(logic idx, logic [31:0] val);
    row_t row;
    row = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic send_obs(obs_t o, bit typed, action_e typed_act);
    int unsigned gap;
    action_e     act;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    now_ms_i       <= o.now_ms;
    fault_latch_i  <= o.fault_latch;
    ctrl_rdy_i     <= o.ctrl_rdy;
    session_live_i <= o.session_live;
    mount_gen_i    <= o.mount_gen;
    dispatch_cnt_i <= o.dispatch_cnt;
    do @(posedge clk_i); while (in_stall_o);
    act = predict_action(o);
    if (typed) act = typed_act;
    pending_actions.push_back(act);
    n_obs++;
    if (act == ACT_RESTART) n_restart++;
    if (act == ACT_REMOUNT) n_remount++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_reg(logic idx, logic [31:0] val);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_RESTART_DELAY) restart_delay = val;
    else idle_delay = val;
    n_cfg++;
  endtask

  // result side: check every transaction, then pick the next stall
  initial begin
    int unsigned hold;
    action_e     exp_act;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_actions.size() == 0) begin
          $error("unexpected transaction: action %0d", action_o);
          fail_cnt++;
        end else begin
          exp_act = pending_actions.pop_front();
          if (action_o !== exp_act) begin
            $error("action mismatch: expected %0d actual %0d", exp_act, action_o);
            fail_cnt++;
          end
        end
      end
      if (hold > 0) hold--;
      else hold = pick_gap();
      out_stall_i <= (hold > 0);
    end
  end

  initial begin
    row_t row;
    obs_t o;
    clear_watchdog();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fatal latch with backwards clock, then idle backoff across generations
    dir_rows.push_back(obs_row(32'd0, 0, 0, 0, 32'd0, 32'd0, 1, ACT_NONE));
    dir_rows.push_back(obs_row(32'd100, 1, 0, 0, 32'd0, 32'd0));
    dir_rows.push_back(obs_row(32'd50, 1, 0, 0, 32'd0, 32'd0));
    dir_rows.push_back(obs_row(32'd60050, 1, 0, 0, 32'd0, 32'd0, 1, ACT_RESTART));
    dir_rows.push_back(obs_row(32'd70000, 1, 0, 0, 32'd0, 32'd0));
    dir_rows.push_back(obs_row(32'd70001, 0, 1, 0, 32'd1, 32'd0));
    dir_rows.push_back(obs_row(32'd160001, 0, 1, 0, 32'd1, 32'd0, 1, ACT_REMOUNT));
    dir_rows.push_back(obs_row(32'd200000, 0, 1, 0, 32'd1, 32'd0));
    dir_rows.push_back(obs_row(32'd200001, 0, 1, 0, 32'd2, 32'd0));
    dir_rows.push_back(obs_row(32'd380000, 0, 1, 0, 32'd2, 32'd0));
    dir_rows.push_back(obs_row(32'd380001, 0, 1, 0, 32'd2, 32'd0));
    dir_rows.push_back(obs_row(32'd380002, 0, 1, 0, 32'd3, 32'd0));
    dir_rows.push_back(obs_row(32'd380001, 0, 1, 0, 32'd3, 32'd0));
    dir_rows.push_back(obs_row(32'd740001, 0, 1, 0, 32'd3, 32'd0));
    dir_rows.push_back(obs_row(32'd740002, 0, 1, 1, 32'd3, 32'd0));
    dir_rows.push_back(obs_row(32'd740003, 0, 1, 0, 32'd3, 32'd5));
    dir_rows.push_back(obs_row(32'd830003, 0, 1, 0, 32'd3, 32'd5));
    dir_rows.push_back(obs_row(32'hFFFF_FFFF, 1, 0, 0, 32'd3, 32'd5));
    dir_rows.push_back(obs_row(32'hFFFF_FFFF, 0, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    dir_rows.push_back(obs_row(32'd0, 0, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // zero delays: restart on first sight of the latch, idle remount off
    dir_rows.push_back(cfg_row(CFG_RESTART_DELAY, 32'd0));
    dir_rows.push_back(cfg_row(CFG_IDLE_DELAY, 32'd0));
    dir_rows.push_back(obs_row(32'd5, 1, 1, 1, 32'd7, 32'd1, 1, ACT_RESTART));
    dir_rows.push_back(obs_row(32'd10, 0, 1, 0, 32'd7, 32'd1, 1, ACT_NONE));
    // widest delays: only a full 32-bit elapsed time reaches them
    dir_rows.push_back(cfg_row(CFG_RESTART_DELAY, 32'hFFFF_FFFF));
    dir_rows.push_back(cfg_row(CFG_IDLE_DELAY, 32'hFFFF_FFFF));
    dir_rows.push_back(obs_row(32'd0, 1, 0, 0, 32'd0, 32'd0));
    dir_rows.push_back(obs_row(32'hFFFF_FFFF, 1, 0, 0, 32'd0, 32'd0, 1, ACT_RESTART));
    dir_rows.push_back(obs_row(32'd1, 0, 1, 0, 32'd9, 32'd2));
    dir_rows.push_back(obs_row(32'd0, 0, 1, 0, 32'd9, 32'd2));
    dir_rows.push_back(obs_row(32'hFFFF_FFFF, 0, 1, 0, 32'd9, 32'd2, 1, ACT_REMOUNT));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) set_reg(row.reg_idx, row.reg_val);
      else send_obs(row.o, row.typed, row.act);
    end

    foreach (plan[p]) begin
      set_reg(CFG_RESTART_DELAY, plan[p].rdelay);
      set_reg(CFG_IDLE_DELAY, plan[p].idelay);
      idle_en = plan[p].gaps;
      repeat (plan[p].n) begin
        if ($urandom_range(0, 99) == 0) drain_results();
        send_obs(rand_obs(plan[p].step), 1'b0, ACT_NONE);
      end
    end

    // walk the backoff past the shift cap: new generation, then wait out the window
    set_reg(CFG_RESTART_DELAY, 32'd1);
    set_reg(CFG_IDLE_DELAY, 32'd1);
    idle_en = 1'b1;
    repeat (12) begin
      walk_gen = (walk_gen == 32'hFFFF_FFFF) ? 32'd1 : walk_gen + 32'd1;
      o.now_ms       = walk_now;
      o.fault_latch  = 1'b0;
      o.ctrl_rdy     = 1'b1;
      o.session_live = 1'b0;
      o.mount_gen    = walk_gen;
      o.dispatch_cnt = walk_disp;
      send_obs(o, 1'b0, ACT_NONE);
      walk_now = walk_now + 32'd8 + $urandom_range(0, 3);
      o.now_ms = walk_now;
      send_obs(o, 1'b0, ACT_NONE);
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    $display("covered %0d observations under %0d register writes", n_obs, n_cfg);
    $display("%0d restarts and %0d remounts seen, backoff streak peaked at %0d",
             n_restart, n_remount, streak_peak);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
